// File: rtl/ppr_pkg.sv
// Shared types, constants and weight function for the partial permutation ranker.
package ppr_pkg;

  // Fixed carriers: twelve slot fields and eight tile value registers.
  localparam int NUM_SLOTS = 12;
  localparam int NUM_TILES = 8;
  localparam int SLOT_W    = 4;
  localparam int POS_W     = 4;
  localparam int CNT_W     = 3;
  localparam int RANK_W    = 25;
  localparam int CFG_IDX_W = 3;

  // Default sizes handed to the top level.
  localparam int DEF_SLOT_COUNT = 12;
  localparam int DEF_TILE_COUNT = 8;

  // Tile values loaded at reset.
  localparam logic [SLOT_W-1:0] TILE_RESET [NUM_TILES] = '{
    4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8
  };

  typedef logic [NUM_SLOTS-1:0][SLOT_W-1:0] slot_vec_t;

  // Slot found by one lane and whether the tile matched at all.
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             found;
  } lane_pos_t;

  // Weighted term of one lane, with its found flag carried along.
  typedef struct packed {
    logic [RANK_W-1:0] term;
    logic              found;
  } lane_term_t;

  // Load enables of the pipeline stages.
  typedef struct packed {
    logic en_find;
    logic en_term;
    logic en_pair;
    logic en_out;
  } pipe_ctl_t;

  // Falling product of the remaining slot counts for tile position i.
  function automatic logic [RANK_W-1:0] weight_of(int i, int slots, int tiles);
    longint w;
    w = 1;
    for (int k = i + 1; k < tiles; k++) begin
      if (slots > k) begin
        w = w * longint'(slots - k);
      end else begin
        w = 0;
      end
    end
    return w[RANK_W-1:0];
  endfunction

  function automatic int min_int(int a, int b);
    return (a > b) ? b : a;
  endfunction

endpackage

// File: rtl/ppr_find.sv
// One lane's first-match slot search, registered.
module ppr_find #(
  parameter int EFF_SLOTS = 12
) (
  input  logic                                clk,
  input  logic                                en,
  input  ppr_pkg::slot_vec_t                  slots,
  input  logic [ppr_pkg::SLOT_W-1:0]          tile_value,
  output ppr_pkg::lane_pos_t                  pos_r
);
  import ppr_pkg::*;

  lane_pos_t pos_nxt;

  // Scan from the top down so the lowest matching slot wins.
  always_comb begin
    pos_nxt.pos   = '0;
    pos_nxt.found = 1'b0;
    for (int j = EFF_SLOTS - 1; j >= 0; j--) begin
      if (slots[j] == tile_value) begin
        pos_nxt.pos   = POS_W'(j);
        pos_nxt.found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// File: rtl/ppr_term.sv
// One lane's slot adjustment and weighting, registered.
module ppr_term #(
  parameter int LANE      = 0,
  parameter int LANES     = 8,
  parameter int EFF_SLOTS = 12
) (
  input  logic                clk,
  input  logic                en,
  input  ppr_pkg::lane_pos_t  pos_all [LANES],
  output ppr_pkg::lane_term_t term_r
);
  import ppr_pkg::*;

  localparam logic [RANK_W-1:0] WEIGHT = weight_of(LANE, EFF_SLOTS, LANES);

  logic [CNT_W-1:0]  cnt;
  logic [RANK_W-1:0] adj;
  lane_term_t        term_nxt;

  // Count earlier tiles at a strictly lower slot.
  always_comb begin
    cnt = '0;
    for (int j = 0; j < LANES; j++) begin
      if (j < LANE && pos_all[j].pos < pos_all[LANE].pos) begin
        cnt = cnt + CNT_W'(1);
      end
    end
  end

  // The adjusted slot may wrap below zero; the rank is taken modulo its width.
  always_comb begin
    adj            = RANK_W'(pos_all[LANE].pos) - RANK_W'(cnt);
    term_nxt.term  = adj * WEIGHT;
    term_nxt.found = pos_all[LANE].found;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= term_nxt;
    end
  end

endmodule

// File: rtl/ppr_merge.sv
// Two-level registered sum of the lane terms and the missing flag.
module ppr_merge #(
  parameter int LANES = 8
) (
  input  logic                          clk,
  input  ppr_pkg::pipe_ctl_t            ctl,
  input  ppr_pkg::lane_term_t           terms [LANES],
  output logic [ppr_pkg::RANK_W-1:0]    rank_r,
  output logic                          missing_r
);
  import ppr_pkg::*;

  localparam int PAIRS = (LANES + 1) / 2;

  logic [RANK_W-1:0] pair_r   [PAIRS];
  logic [RANK_W-1:0] pair_nxt [PAIRS];
  logic              pair_missing_r;
  logic              pair_missing_nxt;
  logic [RANK_W-1:0] rank_nxt;

  // First level: add neighboring lanes and gather the found flags.
  always_comb begin
    pair_missing_nxt = 1'b0;
    for (int k = 0; k < PAIRS; k++) begin
      pair_nxt[k] = terms[2*k].term;
      if (2*k + 1 < LANES) begin
        pair_nxt[k] = terms[2*k].term + terms[2*k+1].term;
      end
    end
    for (int k = 0; k < LANES; k++) begin
      pair_missing_nxt = pair_missing_nxt | ~terms[k].found;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_pair) begin
      pair_r         <= pair_nxt;
      pair_missing_r <= pair_missing_nxt;
    end
  end

  // Second level: add the pair sums into the output register.
  always_comb begin
    rank_nxt = '0;
    for (int k = 0; k < PAIRS; k++) begin
      rank_nxt = rank_nxt + pair_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_out) begin
      rank_r    <= rank_nxt;
      missing_r <= pair_missing_r;
    end
  end

endmodule

// File: rtl/partial_permutation_rank.sv
// Throughput: one item per cycle while the output is not stalled; four register stages
// (lane search, lane weighting, pair sum, final sum) fill bubbles under stall.
// Reset (synchronous, rst_n low): all stage valids clear and the tile value
// registers return to 1 through 8.
// Top level of the partial permutation ranker.
module partial_permutation_rank #(
  parameter int SLOT_COUNT = ppr_pkg::DEF_SLOT_COUNT,
  parameter int TILE_COUNT = ppr_pkg::DEF_TILE_COUNT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [ppr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppr_pkg::SLOT_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ppr_pkg::SLOT_W-1:0]      in_slot_0,
  input  logic [ppr_pkg::SLOT_W-1:0]      in_slot_1,
  input  logic [ppr_pkg::SLOT_W-1:0]      in_slot_2,
  input  logic [ppr_pkg::SLOT_W-1:0]      in_slot_3,
  input  logic [ppr_pkg::SLOT_W-1:0]      in_slot_4,
  input  logic [ppr_pkg::SLOT_W-1:0]      in_slot_5,
  input  logic [ppr_pkg::SLOT_W-1:0]      in_slot_6,
  input  logic [ppr_pkg::SLOT_W-1:0]      in_slot_7,
  input  logic [ppr_pkg::SLOT_W-1:0]      in_slot_8,
  input  logic [ppr_pkg::SLOT_W-1:0]      in_slot_9,
  input  logic [ppr_pkg::SLOT_W-1:0]      in_slot_10,
  input  logic [ppr_pkg::SLOT_W-1:0]      in_slot_11,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ppr_pkg::RANK_W-1:0]      out_rank_index,
  output logic                            out_tile_missing
);
  import ppr_pkg::*;

  localparam int EFF_SLOTS = min_int(SLOT_COUNT, NUM_SLOTS);
  localparam int LANES     = min_int(TILE_COUNT, NUM_TILES);

  logic [SLOT_W-1:0] tile_r [NUM_TILES];
  slot_vec_t         slots;
  pipe_ctl_t         ctl;
  logic              v_find_r;
  logic              v_term_r;
  logic              v_pair_r;
  logic              out_valid_r;
  lane_pos_t         pos_all   [LANES];
  lane_term_t        terms_all [LANES];

  assign slots = {in_slot_11, in_slot_10, in_slot_9, in_slot_8, in_slot_7, in_slot_6,
                  in_slot_5, in_slot_4, in_slot_3, in_slot_2, in_slot_1, in_slot_0};

  // Tile value registers; the user must write them only while the pipeline is idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_r <= TILE_RESET;
    end else if (cfg_wr_en) begin
      tile_r[cfg_index] <= cfg_data;
    end
  end

  // A stage loads when it is empty or the next stage loads as well.
  always_comb begin
    ctl.en_out  = !out_valid_r || !out_stall;
    ctl.en_pair = !v_pair_r || ctl.en_out;
    ctl.en_term = !v_term_r || ctl.en_pair;
    ctl.en_find = !v_find_r || ctl.en_term;
  end

  assign in_stall = !ctl.en_find;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_find_r    <= 1'b0;
      v_term_r    <= 1'b0;
      v_pair_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.en_find) begin
        v_find_r <= in_valid;
      end
      if (ctl.en_term) begin
        v_term_r <= v_find_r;
      end
      if (ctl.en_pair) begin
        v_pair_r <= v_term_r;
      end
      if (ctl.en_out) begin
        out_valid_r <= v_pair_r;
      end
    end
  end

  // One search lane and one weighting lane per tile.
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    ppr_find #(
      .EFF_SLOTS (EFF_SLOTS)
    ) u_find (
      .clk        (clk),
      .en         (ctl.en_find),
      .slots      (slots),
      .tile_value (tile_r[i]),
      .pos_r      (pos_all[i])
    );

    ppr_term #(
      .LANE      (i),
      .LANES     (LANES),
      .EFF_SLOTS (EFF_SLOTS)
    ) u_term (
      .clk     (clk),
      .en      (ctl.en_term),
      .pos_all (pos_all),
      .term_r  (terms_all[i])
    );
  end

  // Merge the lane terms into the rank.
  ppr_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk       (clk),
    .ctl       (ctl),
    .terms     (terms_all),
    .rank_r    (out_rank_index),
    .missing_r (out_tile_missing)
  );

  assign out_valid = out_valid_r;

  // The input side stalls only when every stage is full and the output is held.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v_find_r && v_term_r && v_pair_r && out_valid_r && out_stall))
    else $error("input stalled with a free pipeline stage");

  // An accepted transfer occupies the first stage on the next cycle.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_find_r)
    else $error("accepted item did not reach the search stage");

  // A held result in the pair stage stays while the output cannot take it.
  a_pair_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_pair_r && !ctl.en_pair) |=> v_pair_r)
    else $error("pair stage item lost under stall");

  // The output result is not dropped while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_rank_index)
                                    && $stable(out_tile_missing)))
    else $error("stalled result changed or vanished");

endmodule

// File: verif/tb_partial_permutation_rank.sv
// Self-checking testbench for the partial permutation ranker, with queue-fed driver and monitor.
`timescale 1ns / 1ps

module tb_partial_permutation_rank;
  import ppr_pkg::*;

  typedef logic [SLOT_W-1:0] tile_set_t [NUM_TILES];

  // Predicted outcome of ranking one puzzle state.
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              missing;
  } rank_result_t;

  // Kinds of random puzzle states.
  typedef enum int {
    STATE_WELL_FORMED,
    STATE_BROKEN,
    STATE_NOISE
  } state_kind_t;

  // Tile registers sit at consecutive indexes from here.
  localparam int TILE_REG_BASE = 0;
  localparam int IDLE_PERCENT  = 27;
  localparam int RANDOM_PER_SETTING = 190;
  localparam int DRAIN_CYCLES  = 8;

  // Falling products of the remaining slot counts, 12 slots and 8 tiles.
  localparam int unsigned TILE_WEIGHT [NUM_TILES] = '{
    1663200, 151200, 15120, 1680, 210, 30, 5, 1
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SLOT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  slot_vec_t cur_state = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [RANK_W-1:0] out_rank_index;
  logic out_tile_missing;

  // Stimulus and scoreboard state.
  slot_vec_t pending_states[$];
  rank_result_t rank_expect_q[$];
  rank_result_t oldest_rank;
  tile_set_t tile_cfg = TILE_RESET;
  bit steady = 1'b0;
  int error_count = 0;
  int states_ranked = 0;
  int states_missing = 0;
  int settings_used = 1;

  partial_permutation_rank dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_slot_0        (cur_state[0]),
    .in_slot_1        (cur_state[1]),
    .in_slot_2        (cur_state[2]),
    .in_slot_3        (cur_state[3]),
    .in_slot_4        (cur_state[4]),
    .in_slot_5        (cur_state[5]),
    .in_slot_6        (cur_state[6]),
    .in_slot_7        (cur_state[7]),
    .in_slot_8        (cur_state[8]),
    .in_slot_9        (cur_state[9]),
    .in_slot_10       (cur_state[10]),
    .in_slot_11       (cur_state[11]),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rank_index   (out_rank_index),
    .out_tile_missing (out_tile_missing)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Locate each tile at its first match, adjust for earlier lower tiles, weight and sum.
  function automatic rank_result_t rank_of_state(slot_vec_t st, tile_set_t tiles);
    logic [POS_W-1:0] pos [NUM_TILES];
    rank_result_t ranked;
    int unsigned rank_sum;
    int unsigned adj;
    bit hit;
    ranked.missing = 1'b0;
    rank_sum = 0;
    for (int i = 0; i < NUM_TILES; i++) begin
      pos[i] = '0;
      hit = 1'b0;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        if (!hit && st[j] == tiles[i]) begin
          pos[i] = POS_W'(j);
          hit = 1'b1;
        end
      end
      if (!hit) begin
        ranked.missing = 1'b1;
      end
    end
    for (int i = 0; i < NUM_TILES; i++) begin
      adj = pos[i];
      for (int j = 0; j < i; j++) begin
        if (pos[j] < pos[i]) begin
          adj--;
        end
      end
      rank_sum += adj * TILE_WEIGHT[i];
    end
    ranked.rank = rank_sum[RANK_W-1:0];
    return ranked;
  endfunction

  function automatic bit in_tile_set(logic [SLOT_W-1:0] v, tile_set_t tiles);
    for (int i = 0; i < NUM_TILES; i++) begin
      if (tiles[i] == v) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // A well-formed state holds every tile once at a distinct slot, the rest filler.
  function automatic slot_vec_t random_state(state_kind_t kind, tile_set_t tiles);
    slot_vec_t st;
    int order [NUM_SLOTS];
    int pick;
    int swap;
    logic [SLOT_W-1:0] filler;
    if (kind == STATE_NOISE) begin
      for (int j = 0; j < NUM_SLOTS; j++) begin
        st[j] = SLOT_W'($urandom_range(15));
      end
      return st;
    end
    for (int j = 0; j < NUM_SLOTS; j++) begin
      order[j] = j;
      do begin
        filler = SLOT_W'($urandom_range(15));
      end while (in_tile_set(filler, tiles));
      st[j] = filler;
    end
    for (int j = NUM_SLOTS - 1; j > 0; j--) begin
      pick = $urandom_range(j);
      swap = order[j];
      order[j] = order[pick];
      order[pick] = swap;
    end
    for (int i = 0; i < NUM_TILES; i++) begin
      st[order[i]] = tiles[i];
    end
    if (kind == STATE_BROKEN) begin
      st[$urandom_range(NUM_SLOTS - 1)] = SLOT_W'($urandom_range(15));
    end
    return st;
  endfunction

  // Wait until every queued state has been ranked and checked.
  task automatic wait_drained();
    while (pending_states.size() != 0 || in_valid || rank_expect_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Write all tile registers while the block is idle.
  task automatic write_tiles(tile_set_t vals);
    for (int i = 0; i < NUM_TILES; i++) begin
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_IDX_W'(TILE_REG_BASE + i);
      cfg_data  <= vals[i];
      tile_cfg[i] = vals[i];
    end
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // Mostly well-formed states, the rest broken or pure noise.
  task automatic queue_random(int count);
    int roll;
    @(negedge clk);
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        pending_states.push_back(random_state(STATE_WELL_FORMED, tile_cfg));
      end else if (roll < 85) begin
        pending_states.push_back(random_state(STATE_BROKEN, tile_cfg));
      end else begin
        pending_states.push_back(random_state(STATE_NOISE, tile_cfg));
      end
    end
  endtask

  // Input driver: record the prediction on each transfer, then load the next state.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        rank_expect_q.push_back(rank_of_state(cur_state, tile_cfg));
        states_ranked++;
        if (rank_expect_q[$].missing) begin
          states_missing++;
        end
      end
      if (!in_valid || !in_stall) begin
        if (pending_states.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
          cur_state <= pending_states.pop_front();
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rank_expect_q.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("%0t: unexpected result rank=%0d missing=%0b", $realtime,
                     out_rank_index, out_tile_missing);
          end
        end else begin
          oldest_rank = rank_expect_q.pop_front();
          if (out_rank_index !== oldest_rank.rank ||
              out_tile_missing !== oldest_rank.missing) begin
            error_count++;
            if (error_count <= 10) begin
              $display("%0t: mismatch rank exp=%0d got=%0d, missing exp=%0b got=%0b",
                       $realtime, oldest_rank.rank, out_rank_index,
                       oldest_rank.missing, out_tile_missing);
            end
          end
        end
      end
      out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Run limit.
  initial begin
    #2_000_000;
    $display("tb_partial_permutation_rank failed");
    $finish;
  end

  // Stimulus sequence: directed states under reset tiles, then random under several settings.
  initial begin
    tile_set_t tiles;
    int pick;
    logic [SLOT_W-1:0] swap;
    logic [SLOT_W-1:0] pool [12];
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: sorted, reversed, highest rank, empty, odd values, absent and repeated tiles.
    @(negedge clk);
    pending_states.push_back(48'hCBA987654321);
    pending_states.push_back(48'h123456789ABC);
    pending_states.push_back(48'h12345678CBA9);
    pending_states.push_back(48'h000000000000);
    pending_states.push_back(48'hFFFFFFFFFFFF);
    pending_states.push_back(48'h111111111111);
    pending_states.push_back(48'h0FED87654321);
    pending_states.push_back(48'hCBA907654321);
    pending_states.push_back(48'h876543211122);
    pending_states.push_back(48'hAAAAAAAAAAAA);
    pending_states.push_back(48'h555555555555);
    pending_states.push_back(48'h100000000000);
    queue_random(RANDOM_PER_SETTING - 12);
    wait_drained();

    // Distinct tiles drawn from 1 to 12, with both sides never idling.
    for (int v = 0; v < 12; v++) begin
      pool[v] = SLOT_W'(v + 1);
    end
    for (int v = 11; v > 0; v--) begin
      pick = $urandom_range(v);
      swap = pool[v];
      pool[v] = pool[pick];
      pool[pick] = swap;
    end
    for (int i = 0; i < NUM_TILES; i++) begin
      tiles[i] = pool[i];
    end
    write_tiles(tiles);
    steady = 1'b1;
    queue_random(RANDOM_PER_SETTING);
    wait_drained();
    steady = 1'b0;

    // Extremes: zero matches the first empty slot, values above 12 too.
    tiles = '{4'd0, 4'd15, 4'd1, 4'd12, 4'd13, 4'd14, 4'd2, 4'd11};
    write_tiles(tiles);
    @(negedge clk);
    pending_states.push_back(48'h0000000000F0);
    pending_states.push_back(48'hB2EDC1F00000);
    queue_random(RANDOM_PER_SETTING);
    wait_drained();

    // Repeated tile values share their first matching slot.
    tiles = '{4'd3, 4'd3, 4'd7, 4'd7, 4'd12, 4'd1, 4'd1, 4'd9};
    write_tiles(tiles);
    queue_random(RANDOM_PER_SETTING);
    wait_drained();

    // Arbitrary 4-bit tile values.
    for (int i = 0; i < NUM_TILES; i++) begin
      tiles[i] = SLOT_W'($urandom_range(15));
    end
    write_tiles(tiles);
    queue_random(RANDOM_PER_SETTING);
    wait_drained();

    // Highest legal values, descending.
    tiles = '{4'd12, 4'd11, 4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5};
    write_tiles(tiles);
    queue_random(RANDOM_PER_SETTING);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (rank_expect_q.size() != 0) begin
      error_count += rank_expect_q.size();
      $display("%0d predicted results never arrived", rank_expect_q.size());
    end
    $display("Ranked %0d puzzle states under %0d tile settings, %0d with a tile absent.",
             states_ranked, settings_used, states_missing);
    $display("Mismatches counted: %0d", error_count);
    if (error_count == 0) begin
      $display("tb_partial_permutation_rank passed");
    end else begin
      $display("tb_partial_permutation_rank failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ppr_pkg.sv
rtl/ppr_find.sv
rtl/ppr_term.sv
rtl/ppr_merge.sv
rtl/partial_permutation_rank.sv
verif/tb_partial_permutation_rank.sv
